[rtl/chained_range_translation_top_defines.svh]
// Assertion macros for the chained range translation block.
`ifndef CHAINED_RANGE_TRANSLATION_TOP_DEFINES_SVH
`define CHAINED_RANGE_TRANSLATION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/crt_pkg.sv]
// Types and constants shared by the chained range translation block.
package crt_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ENTRY_W = 3 * DATA_W;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned LIM_W   = 5;

  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_LOAD      = 2'd1,
    ACT_TRANSLATE = 2'd2
  } crt_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_APPLY,
    ST_NEXT,
    ST_DONE
  } crt_state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        stage_index;
    logic [DATA_W-1:0] source_start;
    logic [DATA_W-1:0] dest_start;
    logic [DATA_W-1:0] span_length;
    logic [DATA_W-1:0] key_value;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] translated_value;
    logic [DATA_W-1:0] running_minimum;
    logic              table_full;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic              clear;
    logic              translate;
    logic              overflow;
    logic [DATA_W-1:0] value;
  } crt_event_t;

endpackage

[rtl/chained_range_translation_top.sv]
// Top level of the chained range translation block.
//
// Command words enter on in_word_i when start_i is high and busy_o is low.
// A clear word empties every stage table, resets the running minimum to all
// ones and drops the overflow flag; it gives no result. A load word appends
// an entry to one stage; its result strobes in the cycle after the accept
// and busy_o stays low, so loads may follow every cycle. A translate word
// walks stages 0 to min(stages_in_use, STAGE_COUNT)-1; each stage streams
// its entries from the entry RAM, one read per cycle, to the first covering
// entry, through the setup, scan, apply (on a hit) and next states; the done
// state and result register follow, and busy_o is high for the whole walk.
// result_stb_o is high for exactly one cycle, result_o holds until the next;
// there is no back pressure. cfg_we_i writes stages_in_use (reset value 1)
// and is to be used only while idle; the block does not enforce this. Reset
// clears the stage counts, the minimum and the flag at once; entry RAM
// contents are never read before being written.
module chained_range_translation_top #(
  parameter int unsigned STAGE_COUNT       = 8,
  parameter int unsigned ENTRIES_PER_STAGE = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  crt_pkg::in_word_t         in_word_i,
  output logic                      busy_o,
  input  logic                      cfg_we_i,
  input  logic [crt_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                      result_stb_o,
  output crt_pkg::out_word_t        result_o
);
  import crt_pkg::*;

  localparam int unsigned DEPTH = STAGE_COUNT * ENTRIES_PER_STAGE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crt_event_t        ev;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [CFG_W-1:0]  stages_q;
  logic [DATA_W-1:0] min_q, min_d;
  logic              ovf_q, ovf_d;
  logic              stb_q, stb_d;
  out_word_t         res_q, res_d;

  crt_seq #(
    .STAGE_COUNT      (STAGE_COUNT),
    .ENTRIES_PER_STAGE(ENTRIES_PER_STAGE)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_word_i  (in_word_i),
    .stages_i   (stages_q),
    .busy_o     (busy_o),
    .ev_o       (ev),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata)
  );

  crt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    min_d = min_q;
    ovf_d = ovf_q;
    stb_d = 1'b0;
    res_d = res_q;
    if (ev.clear) begin
      min_d = '1;
      ovf_d = 1'b0;
    end else if (ev.valid) begin
      stb_d = 1'b1;
      if (ev.translate) begin
        if (ev.value < min_q) begin
          min_d = ev.value;
        end
        res_d.translated_value = ev.value;
      end else begin
        ovf_d = ovf_q | ev.overflow;
        res_d.translated_value = '0;
      end
      res_d.running_minimum = min_d;
      res_d.table_full      = ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= CFG_W'(1);
      min_q    <= '1;
      ovf_q    <= 1'b0;
      stb_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stages_q <= cfg_wdata_i;
      end
      min_q <= min_d;
      ovf_q <= ovf_d;
      stb_q <= stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_stb_o = stb_q;
  assign result_o     = res_q;

endmodule

[rtl/crt_ram.sv]
// Generic single-port RAM with registered read data.
module crt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/crt_seq.sv]
// Sequencer: table loads, stage counts and the entry scan for translation.
`include "chained_range_translation_top_defines.svh"

module crt_seq #(
  parameter int unsigned STAGE_COUNT       = 8,
  parameter int unsigned ENTRIES_PER_STAGE = 64,
  localparam int unsigned DEPTH = STAGE_COUNT * ENTRIES_PER_STAGE,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  crt_pkg::in_word_t             in_word_i,
  input  logic [crt_pkg::CFG_W-1:0]     stages_i,
  output logic                          busy_o,
  output crt_pkg::crt_event_t           ev_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_addr_o,
  output logic [crt_pkg::ENTRY_W-1:0]   ram_wdata_o,
  input  logic [crt_pkg::ENTRY_W-1:0]   ram_rdata_i
);
  import crt_pkg::*;

  localparam int unsigned SW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int unsigned CW = $clog2(ENTRIES_PER_STAGE + 1);

  crt_state_e state_q, state_d;
  logic [SW-1:0]     stage_q, stage_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [CW-1:0]     counts_q [STAGE_COUNT];
  logic [CW-1:0]     counts_d [STAGE_COUNT];
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] diff_q, diff_d;
  logic [DATA_W-1:0] dst_q, dst_d;

  crt_action_e       act;
  logic [LIM_W-1:0]  lim;
  logic              last_stage;
  logic              in_range;
  logic [SW-1:0]     ld_stage;
  logic [SW-1:0]     cnt_sel;
  logic [CW-1:0]     cnt_rd;
  logic              full;
  logic [DATA_W-1:0] e_src, e_dst, e_len;
  logic [DATA_W:0]   sub;
  logic              hit_now;
  logic              issue;
  logic [AW-1:0]     ld_addr, scan_addr;

  assign act        = crt_action_e'(in_word_i.action);
  assign lim        = (LIM_W'(stages_i) > LIM_W'(STAGE_COUNT)) ?
                      LIM_W'(STAGE_COUNT) : LIM_W'(stages_i);
  assign last_stage = (LIM_W'(stage_q) + LIM_W'(1)) >= lim;
  assign in_range   = LIM_W'(in_word_i.stage_index) < LIM_W'(STAGE_COUNT);
  assign ld_stage   = SW'(in_word_i.stage_index);
  assign cnt_sel    = (state_q == ST_IDLE) ? ld_stage : stage_q;
  assign cnt_rd     = counts_q[cnt_sel];
  assign full       = cnt_rd >= CW'(ENTRIES_PER_STAGE);

  assign {e_src, e_dst, e_len} = ram_rdata_i;
  assign sub     = {1'b0, key_q} - {1'b0, e_src};
  assign hit_now = rd_vld_q && !sub[DATA_W] && (sub[DATA_W-1:0] < e_len);
  assign issue   = (idx_q < cnt_q) && !hit_now;

  assign ld_addr   = AW'(AW'(ld_stage) * AW'(ENTRIES_PER_STAGE)) + AW'(cnt_rd);
  assign scan_addr = AW'(AW'(stage_q) * AW'(ENTRIES_PER_STAGE)) + AW'(idx_q);

  assign busy_o      = state_q != ST_IDLE;
  assign ram_addr_o  = (state_q == ST_IDLE) ? ld_addr : scan_addr;
  assign ram_wdata_o = {in_word_i.source_start, in_word_i.dest_start,
                        in_word_i.span_length};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && act == ACT_TRANSLATE) begin
          state_d = (lim == '0) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_SCAN;
      ST_SCAN: begin
        if (hit_now) begin
          state_d = ST_APPLY;
        end else if (!issue && !rd_vld_q) begin
          state_d = ST_NEXT;
        end
      end
      ST_APPLY: state_d = ST_NEXT;
      ST_NEXT:  state_d = last_stage ? ST_DONE : ST_SETUP;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    stage_d  = stage_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    rd_vld_d = 1'b0;
    counts_d = counts_q;
    key_d    = key_q;
    diff_d   = diff_q;
    dst_d    = dst_q;
    ram_we_o = 1'b0;
    ev_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        stage_d = '0;
        if (start_i) begin
          case (act)
            ACT_CLEAR: begin
              ev_o.clear = 1'b1;
              for (int s = 0; s < STAGE_COUNT; s++) begin
                counts_d[s] = '0;
              end
            end
            ACT_LOAD: begin
              ev_o.valid = 1'b1;
              if (in_range) begin
                if (full) begin
                  ev_o.overflow = 1'b1;
                end else begin
                  ram_we_o           = 1'b1;
                  counts_d[ld_stage] = cnt_rd + CW'(1);
                end
              end
            end
            ACT_TRANSLATE: key_d = in_word_i.key_value;
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        cnt_d = cnt_rd;
        idx_d = '0;
      end
      ST_SCAN: begin
        rd_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (hit_now) begin
          diff_d = sub[DATA_W-1:0];
          dst_d  = e_dst;
        end
      end
      ST_APPLY: key_d = dst_q + diff_q;
      ST_NEXT: begin
        if (!last_stage) begin
          stage_d = stage_q + SW'(1);
        end
      end
      ST_DONE: begin
        ev_o.valid     = 1'b1;
        ev_o.translate = 1'b1;
        ev_o.value     = key_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stage_q  <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      for (int s = 0; s < STAGE_COUNT; s++) begin
        counts_q[s] <= '0;
      end
    end else begin
      state_q  <= state_d;
      stage_q  <= stage_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      counts_q <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    diff_q <= diff_d;
    dst_q  <= dst_d;
  end

  `CRT_ASSERT_IMP(a_rd_only_in_scan, rd_vld_q, state_q == ST_SCAN, "read pending outside scan")
  `CRT_ASSERT_IMP(a_idx_bound, state_q == ST_SCAN, idx_q <= cnt_q, "scan index past stage count")
  `CRT_ASSERT_IMP(a_write_idle, ram_we_o, !busy_o && start_i, "table write while busy")
  `CRT_ASSERT_NXT(a_done_idle, ev_o.valid && ev_o.translate, state_q == ST_IDLE, "no idle after result")

endmodule
